FILE: rtl/core/rbd_pkg.sv
// Shared types and constants for the ring buffer deque.
package rbd_pkg;

	// Ring geometry.
	localparam int CAPACITY = 16;
	localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int WORD_W   = 32;
	localparam int CFG_W    = 5;
	localparam int KIND_W   = 3;
	localparam int STAT_W   = 2;
	localparam int RES_W    = 72;

	// Operation codes carried in tuser.
	localparam logic [KIND_W-1:0] KIND_PUSH_FRONT = 3'd0;
	localparam logic [KIND_W-1:0] KIND_PUSH_BACK  = 3'd1;
	localparam logic [KIND_W-1:0] KIND_POP_FRONT  = 3'd2;
	localparam logic [KIND_W-1:0] KIND_POP_BACK   = 3'd3;

	// Status codes of a result.
	localparam logic [STAT_W-1:0] STAT_DONE      = 2'd0;
	localparam logic [STAT_W-1:0] STAT_OVERFLOW  = 2'd1;
	localparam logic [STAT_W-1:0] STAT_UNDERFLOW = 2'd2;

	// Word reported for front and back while the deque is empty.
	localparam logic [WORD_W-1:0] EMPTY_WORD = '1;

	// Memory access request from the controller.
	typedef struct packed {
		logic              wr_en;
		logic [IDX_W-1:0]  wr_addr;
		logic [WORD_W-1:0] wr_data;
		logic [IDX_W-1:0]  rd_addr_front;
		logic [IDX_W-1:0]  rd_addr_back;
	} rbd_mem_req_t;

	// Registered read data from the memory.
	typedef struct packed {
		logic [WORD_W-1:0] front;
		logic [WORD_W-1:0] back;
	} rbd_mem_rsp_t;

	// One result, status in the lowest bits.
	typedef struct packed {
		logic              empty_res;
		logic [CFG_W-1:0]  count;
		logic [WORD_W-1:0] back_value;
		logic [WORD_W-1:0] front_value;
		logic [STAT_W-1:0] status;
	} rbd_result_t;

endpackage

FILE: rtl/core/rbd_ram.sv
// Slot memory: one write port and two registered read ports.
module rbd_ram (
	input  logic                 clk,
	input  rbd_pkg::rbd_mem_req_t req,
	output rbd_pkg::rbd_mem_rsp_t rsp
);
	import rbd_pkg::*;

	logic [WORD_W-1:0] mem [CAPACITY];

	// Write port.
	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			mem[req.wr_addr] <= req.wr_data;
		end
	end

	// Two registered read ports.
	always_ff @(posedge clk) begin
		rsp.front <= mem[req.rd_addr_front];
		rsp.back  <= mem[req.rd_addr_back];
	end

endmodule

FILE: rtl/core/rbd_ctrl.sv
// Deque controller: pointer update, sequencing and result register.
module rbd_ctrl (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [rbd_pkg::CFG_W-1:0]     cfg_data,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [rbd_pkg::KIND_W-1:0]    in_kind,
	input  logic [rbd_pkg::WORD_W-1:0]    in_data,
	output logic                          out_valid,
	input  logic                          out_ready,
	output rbd_pkg::rbd_result_t          out_res,
	output rbd_pkg::rbd_mem_req_t         mem_req,
	input  rbd_pkg::rbd_mem_rsp_t         mem_rsp
);
	import rbd_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_READ,
		ST_EMIT
	} state_t;

	state_t            state_q;
	logic [IDX_W-1:0]  head_q;
	logic [IDX_W-1:0]  tail_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [CNT_W-1:0]  cap_q;
	logic [STAT_W-1:0] status_q;
	logic              out_valid_q;
	rbd_result_t       out_res_q;

	logic              accept;
	logic [IDX_W-1:0]  head_nx;
	logic [IDX_W-1:0]  tail_nx;
	logic [CNT_W-1:0]  cnt_nx;
	logic [STAT_W-1:0] status_nx;
	logic              wr_en;
	logic [IDX_W-1:0]  wr_addr;
	logic [IDX_W-1:0]  cap_last;
	logic [IDX_W-1:0]  head_inc;
	logic [IDX_W-1:0]  tail_inc;
	logic [CNT_W-1:0]  cfg_cap;
	logic              out_free;
	logic              out_load;

	assign accept    = in_valid && in_ready;
	assign in_ready  = (state_q == ST_IDLE);
	// A capacity write is taken only between operations.
	assign cfg_ready = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;
	assign out_res   = out_res_q;
	assign out_free  = !out_valid_q || out_ready;
	assign out_load  = (state_q == ST_EMIT) && out_free;

	// Wrapped neighbors of the head and tail within the active ring size.
	assign cap_last = IDX_W'(cap_q - CNT_W'(1));
	assign head_inc = (CNT_W'(head_q) + CNT_W'(1) >= cap_q) ? '0 : IDX_W'(head_q + 1'b1);
	assign tail_inc = (CNT_W'(tail_q) + CNT_W'(1) >= cap_q) ? '0 : IDX_W'(tail_q + 1'b1);

	// Clamp a written capacity into one through the ring size.
	always_comb begin
		if (cfg_data == '0) begin
			cfg_cap = CNT_W'(1);
		end else if (32'(cfg_data) > 32'(CAPACITY)) begin
			cfg_cap = CNT_W'(CAPACITY);
		end else begin
			cfg_cap = CNT_W'(cfg_data);
		end
	end

	// Next pointers, count, status and slot write for the incoming operation.
	always_comb begin
		head_nx   = head_q;
		tail_nx   = tail_q;
		cnt_nx    = cnt_q;
		status_nx = STAT_DONE;
		wr_en     = 1'b0;
		wr_addr   = '0;
		unique case (in_kind)
			KIND_PUSH_FRONT, KIND_PUSH_BACK: begin
				if (cnt_q >= cap_q) begin
					status_nx = STAT_OVERFLOW;
				end else if (cnt_q == '0) begin
					head_nx = '0;
					tail_nx = '0;
					cnt_nx  = CNT_W'(1);
					wr_en   = 1'b1;
					wr_addr = '0;
				end else if (in_kind == KIND_PUSH_FRONT) begin
					head_nx = (head_q == '0) ? cap_last : IDX_W'(head_q - 1'b1);
					cnt_nx  = cnt_q + CNT_W'(1);
					wr_en   = 1'b1;
					wr_addr = head_nx;
				end else begin
					tail_nx = tail_inc;
					cnt_nx  = cnt_q + CNT_W'(1);
					wr_en   = 1'b1;
					wr_addr = tail_inc;
				end
			end
			KIND_POP_FRONT, KIND_POP_BACK: begin
				if (cnt_q == '0) begin
					status_nx = STAT_UNDERFLOW;
				end else if (cnt_q == CNT_W'(1)) begin
					head_nx = '0;
					tail_nx = '0;
					cnt_nx  = '0;
				end else if (in_kind == KIND_POP_FRONT) begin
					head_nx = head_inc;
					cnt_nx  = cnt_q - CNT_W'(1);
				end else begin
					tail_nx = (tail_q == '0) ? cap_last : IDX_W'(tail_q - 1'b1);
					cnt_nx  = cnt_q - CNT_W'(1);
				end
			end
			default: begin
				status_nx = STAT_DONE;
			end
		endcase
	end

	// Memory request: the write lands at the accept edge, the reads follow the pointers.
	always_comb begin
		mem_req.wr_en         = accept && wr_en;
		mem_req.wr_addr       = wr_addr;
		mem_req.wr_data       = in_data;
		mem_req.rd_addr_front = head_q;
		mem_req.rd_addr_back  = tail_q;
	end

	// Sequencer, pointer registers and result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			head_q      <= '0;
			tail_q      <= '0;
			cnt_q       <= '0;
			cap_q       <= CNT_W'(CAPACITY);
			status_q    <= STAT_DONE;
			out_valid_q <= 1'b0;
			out_res_q   <= '0;
		end else begin
			// A new result takes the output register as the previous one leaves.
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (cfg_valid && cfg_ready && cnt_q == '0) begin
						cap_q  <= cfg_cap;
						head_q <= '0;
						tail_q <= '0;
					end
					if (accept) begin
						head_q   <= head_nx;
						tail_q   <= tail_nx;
						cnt_q    <= cnt_nx;
						status_q <= status_nx;
						state_q  <= ST_READ;
					end
				end
				ST_READ: begin
					state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (out_free) begin
						out_res_q.status      <= status_q;
						out_res_q.count       <= CFG_W'(cnt_q);
						out_res_q.empty_res   <= (cnt_q == '0);
						out_res_q.front_value <= (cnt_q == '0) ? EMPTY_WORD : mem_rsp.front;
						out_res_q.back_value  <= (cnt_q == '0) ? EMPTY_WORD : mem_rsp.back;
						state_q               <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

FILE: rtl/core/ring_buffer_deque.sv
// Ring buffer deque of signed words: a controller around a two-read slot memory.
// Sequencing: an input transaction is accepted only in the idle state, where its slot write
// is made; the registered memory read of front and back and the load of the result register
// follow, and the next input is not taken until the result register has been loaded.
// Reset: arst_n clears the pointers and count, sets capacity to its maximum;
// the slot memory is not cleared and no slot is reported before it is written.
module ring_buffer_deque (
	input  logic                         clk,
	input  logic                         arst_n,
	// Configuration write channel: capacity.
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [rbd_pkg::CFG_W-1:0]    cfg_data,
	// Input stream.
	input  logic                         s_axis_tvalid,
	output logic                         s_axis_tready,
	input  logic [31:0]                  s_axis_tdata,  // [31:0] data
	input  logic [2:0]                   s_axis_tuser,  // [2:0] kind
	// Result stream.
	output logic                         m_axis_tvalid,
	input  logic                         m_axis_tready,
	// [1:0] status, [33:2] front_value, [65:34] back_value, [70:66] count, [71] empty_res
	output logic [rbd_pkg::RES_W-1:0]    m_axis_tdata
);
	import rbd_pkg::*;

	rbd_mem_req_t mem_req;
	rbd_mem_rsp_t mem_rsp;
	rbd_result_t  res;

	// Pointer and sequencing logic.
	rbd_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.in_kind   (s_axis_tuser),
		.in_data   (s_axis_tdata),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_res   (res),
		.mem_req   (mem_req),
		.mem_rsp   (mem_rsp)
	);

	// Slot storage.
	rbd_ram u_ram (
		.clk (clk),
		.req (mem_req),
		.rsp (mem_rsp)
	);

	assign m_axis_tdata = res;

endmodule

FILE: tb/ring_buffer_deque_checker.sv
// Checker that predicts each ring buffer deque result and compares it with the result stream.
`timescale 1ns / 1ps

module ring_buffer_deque_checker (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_valid,
	input  logic                      cfg_ready,
	input  logic [rbd_pkg::CFG_W-1:0] cfg_data,
	input  logic                      s_axis_tvalid,
	input  logic                      s_axis_tready,
	input  logic [31:0]               s_axis_tdata,  // [31:0] data
	input  logic [2:0]                s_axis_tuser,  // [2:0] kind
	input  logic                      m_axis_tvalid,
	input  logic                      m_axis_tready,
	// [1:0] status, [33:2] front_value, [65:34] back_value, [70:66] count, [71] empty_res
	input  logic [rbd_pkg::RES_W-1:0] m_axis_tdata,
	output int                        mismatches,
	output int                        outstanding
);
	import rbd_pkg::*;

	// Mirror of the deque: slot words, ring pointers, word count and capacity in use.
	logic [WORD_W-1:0] slots [CAPACITY];
	logic [IDX_W-1:0]  head;
	logic [IDX_W-1:0]  tail;
	logic [CNT_W-1:0]  held;
	logic [CFG_W-1:0]  cap;

	// Results predicted for accepted operations, oldest first.
	rbd_result_t awaited_results [$];
	rbd_result_t want;
	rbd_result_t got;

	// A capacity write only takes effect while the deque holds nothing.
	function automatic void take_capacity(input logic [CFG_W-1:0] value);
		if (held != '0)
			return;
		if (value == '0)
			cap = CFG_W'(1);
		else if (value > CFG_W'(CAPACITY))
			cap = CFG_W'(CAPACITY);
		else
			cap = value;
		head = '0;
		tail = '0;
	endfunction

	// Apply one operation to the mirror and return the result it must produce.
	function automatic rbd_result_t apply_deque_op(input logic [KIND_W-1:0] op,
			input logic [WORD_W-1:0] word);
		rbd_result_t r;
		r.status = STAT_DONE;
		if (op == KIND_PUSH_FRONT || op == KIND_PUSH_BACK) begin
			if (held >= cap) begin
				r.status = STAT_OVERFLOW;
			end else if (held == '0) begin
				// The first word always lands in slot zero.
				head = '0;
				tail = '0;
				slots[0] = word;
				held = CNT_W'(1);
			end else if (op == KIND_PUSH_FRONT) begin
				head = (head == '0) ? IDX_W'(cap - 1) : head - 1'b1;
				slots[head] = word;
				held++;
			end else begin
				tail = (int'(tail) + 1 >= int'(cap)) ? '0 : tail + 1'b1;
				slots[tail] = word;
				held++;
			end
		end else if (op == KIND_POP_FRONT || op == KIND_POP_BACK) begin
			if (held == '0) begin
				r.status = STAT_UNDERFLOW;
			end else if (held == CNT_W'(1)) begin
				// Taking the last word rewinds both pointers.
				held = '0;
				head = '0;
				tail = '0;
			end else if (op == KIND_POP_FRONT) begin
				head = (int'(head) + 1 >= int'(cap)) ? '0 : head + 1'b1;
				held--;
			end else begin
				tail = (tail == '0) ? IDX_W'(cap - 1) : tail - 1'b1;
				held--;
			end
		end
		// Peek and the spare kinds leave the deque untouched.
		if (held == '0) begin
			r.front_value = EMPTY_WORD;
			r.back_value  = EMPTY_WORD;
			r.empty_res   = 1'b1;
		end else begin
			r.front_value = slots[head];
			r.back_value  = slots[tail];
			r.empty_res   = 1'b0;
		end
		r.count = CFG_W'(held);
		return r;
	endfunction

	task automatic check_field(input string name, input longint want_v, input longint got_v);
		if (want_v != got_v) begin
			$error("%s mismatch: expected %0d, got %0d", name, want_v, got_v);
			mismatches++;
		end
	endtask

	// Watch all three channels at each rising edge.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head = '0;
			tail = '0;
			held = '0;
			cap = CFG_W'(CAPACITY);
			awaited_results.delete();
			mismatches = 0;
		end else begin
			if (cfg_valid && cfg_ready)
				take_capacity(cfg_data);
			// Compare a result transaction with the oldest prediction.
			if (m_axis_tvalid && m_axis_tready) begin
				got = rbd_result_t'(m_axis_tdata);
				if (awaited_results.size() == 0) begin
					$error("result transaction with no operation awaiting it: %h", m_axis_tdata);
					mismatches++;
				end else begin
					want = awaited_results.pop_front();
					check_field("status", longint'(want.status), longint'(got.status));
					check_field("front_value", longint'($signed(want.front_value)),
						longint'($signed(got.front_value)));
					check_field("back_value", longint'($signed(want.back_value)),
						longint'($signed(got.back_value)));
					check_field("count", longint'(want.count), longint'(got.count));
					check_field("empty_res", longint'(want.empty_res), longint'(got.empty_res));
				end
			end
			// Predict the result of an accepted operation.
			if (s_axis_tvalid && s_axis_tready)
				awaited_results.push_back(apply_deque_op(s_axis_tuser, s_axis_tdata));
		end
		outstanding = awaited_results.size();
	end

endmodule

FILE: tb/ring_buffer_deque_tb.sv
// Top of the ring buffer deque testbench: clock, reset, stimulus, result stalls and verdict.
`timescale 1ns / 1ps

module ring_buffer_deque_tb;
	import rbd_pkg::*;

	// Peek and the spare kinds that behave like it.
	localparam logic [KIND_W-1:0] KIND_PEEK = 3'd4;
	localparam logic [KIND_W-1:0] KIND_LAST = 3'd7;
	localparam logic [WORD_W-1:0] WORD_MAX  = 32'h7FFF_FFFF;
	localparam logic [WORD_W-1:0] WORD_MIN  = 32'h8000_0000;
	localparam int                RUN_LIMIT_NS = 4_000_000;

	logic               clk;
	logic               arst_n;
	logic               cfg_valid;
	logic               cfg_ready;
	logic [CFG_W-1:0]   cfg_data;
	logic               s_axis_tvalid;
	logic               s_axis_tready;
	logic [31:0]        s_axis_tdata;  // [31:0] data
	logic [2:0]         s_axis_tuser;  // [2:0] kind
	logic               m_axis_tvalid;
	logic               m_axis_tready;
	// [1:0] status, [33:2] front_value, [65:34] back_value, [70:66] count, [71] empty_res
	logic [RES_W-1:0]   m_axis_tdata;

	int src_idle_pct   = 0;
	int sink_stall_pct = 0;
	int mismatches;
	int outstanding;

	ring_buffer_deque i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	ring_buffer_deque_checker i_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.mismatches    (mismatches),
		.outstanding   (outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Hard stop in case the block hangs.
	initial begin
		#RUN_LIMIT_NS;
		$display("CHECK FAILED");
		$finish;
	end

	// Result side: stall at the rate of the current phase.
	initial begin
		m_axis_tready = 1'b0;
		forever begin
			@(negedge clk);
			m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
		end
	end

	// Mostly random words, with the extremes mixed in.
	function automatic logic [WORD_W-1:0] pick_word();
		case ($urandom_range(15))
			0: return WORD_MAX;
			1: return WORD_MIN;
			2: return '1;
			3: return '0;
			default: return WORD_W'($urandom);
		endcase
	endfunction

	// Offer one operation after a random gap and hold it until the transaction.
	task automatic send_op(input logic [KIND_W-1:0] op, input logic [WORD_W-1:0] word);
		while ($urandom_range(99) < src_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= op;
		s_axis_tdata  <= word;
		do @(posedge clk); while (!s_axis_tready);
		@(negedge clk);
	endtask

	// Stop sending and wait until every predicted result has been seen.
	task automatic drain();
		s_axis_tvalid <= 1'b0;
		do @(negedge clk); while (outstanding != 0);
	endtask

	task automatic write_capacity(input logic [CFG_W-1:0] value);
		cfg_valid <= 1'b1;
		cfg_data  <= value;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Enough pops to empty the deque at any capacity; the surplus underflows.
	task automatic empty_deque();
		repeat (CAPACITY)
			send_op($urandom_range(1) ? KIND_POP_BACK : KIND_POP_FRONT, pick_word());
	endtask

	// One random phase: set the capacity, then swing between filling and emptying.
	task automatic run_phase(input logic [CFG_W-1:0] cap_val, input bit empty_first,
			input int mode, input int n_items);
		int fill_pct;
		int run_left;
		logic [KIND_W-1:0] op;
		drain();
		if (empty_first) begin
			empty_deque();
			drain();
		end
		write_capacity(cap_val);
		case (mode)
			0: begin
				src_idle_pct   = 0;
				sink_stall_pct = 0;
			end
			1: begin
				src_idle_pct   = 68;
				sink_stall_pct = 0;
			end
			2: begin
				src_idle_pct   = 0;
				sink_stall_pct = 68;
			end
			default: begin
				src_idle_pct   = 11;
				sink_stall_pct = 11;
			end
		endcase
		fill_pct = 20;
		run_left = 0;
		for (int i = 0; i < n_items; i++) begin
			if (run_left == 0) begin
				fill_pct = 100 - fill_pct;
				run_left = $urandom_range(40, 8);
			end
			run_left--;
			if ($urandom_range(99) < 6)
				op = KIND_PEEK + KIND_W'($urandom_range(3));
			else if ($urandom_range(99) < fill_pct)
				op = $urandom_range(1) ? KIND_PUSH_BACK : KIND_PUSH_FRONT;
			else
				op = $urandom_range(1) ? KIND_POP_BACK : KIND_POP_FRONT;
			// Let the pipeline run dry once in the middle of each phase.
			if (i == n_items / 2)
				drain();
			send_op(op, pick_word());
		end
	endtask

	// Stimulus: reset, directed operations, then random phases.
	initial begin
		arst_n        = 1'b0;
		cfg_valid     = 1'b0;
		cfg_data      = '0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		s_axis_tuser  = '0;
		repeat (11) @(negedge clk);
		arst_n <= 1'b1;

		// Pops, peek and the spare kinds on an empty deque.
		send_op(KIND_POP_FRONT, pick_word());
		send_op(KIND_POP_BACK, pick_word());
		for (int k = KIND_PEEK; k <= KIND_LAST; k++)
			send_op(KIND_W'(k), pick_word());

		// Extreme words from both ends, starting with a front push into an empty deque.
		send_op(KIND_PUSH_FRONT, WORD_MAX);
		send_op(KIND_PUSH_BACK, WORD_MIN);
		send_op(KIND_PUSH_FRONT, '1);
		send_op(KIND_PUSH_BACK, '0);
		send_op(KIND_POP_FRONT, pick_word());
		send_op(KIND_POP_BACK, pick_word());
		send_op(KIND_POP_BACK, pick_word());
		send_op(KIND_POP_FRONT, pick_word());

		// A capacity write while a word is held must be ignored.
		send_op(KIND_PUSH_BACK, 32'h1234_5678);
		drain();
		write_capacity(CFG_W'(3));
		send_op(KIND_PUSH_BACK, pick_word());
		send_op(KIND_POP_FRONT, pick_word());
		send_op(KIND_POP_FRONT, pick_word());

		// A capacity of zero acts as one slot.
		drain();
		write_capacity('0);
		send_op(KIND_PUSH_FRONT, pick_word());
		send_op(KIND_PUSH_BACK, pick_word());
		send_op(KIND_PEEK, pick_word());
		send_op(KIND_POP_BACK, pick_word());
		send_op(KIND_POP_BACK, pick_word());

		run_phase(CFG_W'(16), 1'b1, 0, 80);
		run_phase(CFG_W'(1), 1'b1, 1, 80);
		run_phase(CFG_W'(2), 1'b1, 2, 80);
		run_phase(CFG_W'(31), 1'b1, 3, 80);
		run_phase(CFG_W'(0), 1'b1, 0, 80);
		run_phase(CFG_W'(7), 1'b0, 1, 80);
		run_phase(CFG_W'(17), 1'b1, 2, 80);
		run_phase(CFG_W'(5), 1'b1, 3, 80);

		drain();
		repeat (8) @(negedge clk);
		if (mismatches == 0 && outstanding == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

FILE: files.f
rtl/core/rbd_pkg.sv
rtl/core/rbd_ram.sv
rtl/core/rbd_ctrl.sv
rtl/core/ring_buffer_deque.sv
tb/ring_buffer_deque_checker.sv
tb/ring_buffer_deque_tb.sv
